// File: src/bboa_pkg.sv
`default_nettype none

package bboa_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int MAG_W        = COORD_WIDTH;
    localparam int NORM_W       = 30;
    localparam int NORM_TOP     = NORM_W - 1;
    localparam int POS_W        = $clog2(MAG_W + NORM_W);
    localparam int SQ_W         = 2 * NORM_W;
    localparam int SUM_W        = SQ_W + 1;
    localparam int T_W          = SQ_W + 2;
    localparam int LIM_W        = 16;
    localparam int L2_W         = 2 * LIM_W;
    localparam int PL_W         = 2 * L2_W;
    localparam int PH_W         = L2_W + T_W - L2_W;
    localparam int CMP_W        = L2_W + T_W;
    localparam int ISQ_W        = T_W;
    localparam int ISQ_STEPS    = 31;
    localparam int ROOT_W       = 31;
    localparam int CORDIC_STEPS = 23;
    localparam int CRD_W        = 34;
    localparam int ANG_W        = 25;
    localparam int UA_W         = 24;
    localparam int YAW_W        = 15;
    localparam int PITCH_W      = 14;

    localparam logic [LIM_W-1:0] COS_LIMIT_RESET = 16'd65529;
    localparam logic [UA_W-1:0]  DEG90_Q16       = 24'd5898240;
    localparam logic [UA_W-1:0]  DEG180_Q16      = 24'd11796480;
    localparam logic [UA_W-1:0]  HALF_UNIT       = 24'd256;

    localparam logic [ANG_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        25'd2949120, 25'd1740967, 25'd919879, 25'd466945, 25'd234379,
        25'd117304, 25'd58666, 25'd29335, 25'd14668, 25'd7334, 25'd3667,
        25'd1833, 25'd917, 25'd458, 25'd229, 25'd115, 25'd57, 25'd29,
        25'd14, 25'd7, 25'd4, 25'd2, 25'd1
    };

    typedef struct packed {
        logic yaw_ok;
        logic pitch_ok;
        logic dx_neg;
        logic dy_neg;
        logic dz_neg;
    } flag_t;

    typedef struct packed {
        flag_t             f;
        logic [NORM_W-1:0] yx;
        logic [NORM_W-1:0] yz;
        logic [NORM_W-1:0] py;
    } isq_side_t;

endpackage

`default_nettype wire

// File: src/bboa_isqrt.sv
`default_nettype none

module bboa_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       valid_in,
    input  wire logic [bboa_pkg::SUM_W-1:0] s_in,
    input  bboa_pkg::isq_side_t             side_in,
    output logic                            valid_out,
    output logic [bboa_pkg::ROOT_W-1:0]     root_out,
    output bboa_pkg::isq_side_t             side_out
);
    import bboa_pkg::*;

    logic [ISQ_STEPS-1:0] v_reg;
    logic [ISQ_W-1:0]     s_reg    [ISQ_STEPS];
    logic [ISQ_W-1:0]     r_reg    [ISQ_STEPS];
    isq_side_t            side_reg [ISQ_STEPS];
    logic [ISQ_W-1:0]     s_src    [ISQ_STEPS];
    logic [ISQ_W-1:0]     r_src    [ISQ_STEPS];
    isq_side_t            side_src [ISQ_STEPS];
    logic [ISQ_W-1:0]     s_next   [ISQ_STEPS];
    logic [ISQ_W-1:0]     r_next   [ISQ_STEPS];

    always_comb
    begin
        logic [ISQ_W-1:0] b;
        logic [ISQ_W-1:0] rb;
        s_src[0]    = ISQ_W'(s_in);
        r_src[0]    = '0;
        side_src[0] = side_in;
        for (int i = 1; i < ISQ_STEPS; i++)
        begin
            s_src[i]    = s_reg[i-1];
            r_src[i]    = r_reg[i-1];
            side_src[i] = side_reg[i-1];
        end
        for (int i = 0; i < ISQ_STEPS; i++)
        begin
            b  = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - i));
            rb = r_src[i] + b;
            if (s_src[i] >= rb)
            begin
                s_next[i] = s_src[i] - rb;
                r_next[i] = (r_src[i] >> 1) + b;
            end
            else
            begin
                s_next[i] = s_src[i];
                r_next[i] = r_src[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[ISQ_STEPS-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        r_reg    <= r_next;
        side_reg <= side_src;
    end

    assign valid_out = v_reg[ISQ_STEPS-1];
    assign root_out  = r_reg[ISQ_STEPS-1][ROOT_W-1:0];
    assign side_out  = side_reg[ISQ_STEPS-1];

endmodule

`default_nettype wire

// File: src/bboa_cordic.sv
`default_nettype none

module bboa_cordic (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        valid_in,
    input  wire logic [bboa_pkg::NORM_W-1:0] yaw_x,
    input  wire logic [bboa_pkg::NORM_W-1:0] yaw_y,
    input  wire logic [bboa_pkg::ROOT_W-1:0] pitch_x,
    input  wire logic [bboa_pkg::NORM_W-1:0] pitch_y,
    input  bboa_pkg::flag_t                  flags_in,
    output logic                             valid_out,
    output logic signed [bboa_pkg::ANG_W-1:0] yaw_z,
    output logic signed [bboa_pkg::ANG_W-1:0] pitch_z,
    output bboa_pkg::flag_t                  flags_out
);
    import bboa_pkg::*;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } crd_t;

    function automatic crd_t crd_step(crd_t c, int i);
        crd_t r;
        if (c.y > 0)
        begin
            r.x = c.x + (c.y >>> i);
            r.y = c.y - (c.x >>> i);
            r.z = c.z + signed'(ATAN_Q16[i]);
        end
        else
        begin
            r.x = c.x - (c.y >>> i);
            r.y = c.y + (c.x >>> i);
            r.z = c.z - signed'(ATAN_Q16[i]);
        end
        return r;
    endfunction

    logic [CORDIC_STEPS-1:0] v_reg;
    crd_t  yaw_reg   [CORDIC_STEPS];
    crd_t  pitch_reg [CORDIC_STEPS];
    flag_t flag_reg  [CORDIC_STEPS];
    crd_t  yaw_src   [CORDIC_STEPS];
    crd_t  pitch_src [CORDIC_STEPS];
    flag_t flag_src  [CORDIC_STEPS];
    crd_t  yaw_next  [CORDIC_STEPS];
    crd_t  pitch_next[CORDIC_STEPS];

    always_comb
    begin
        yaw_src[0].x   = signed'(CRD_W'(yaw_x));
        yaw_src[0].y   = signed'(CRD_W'(yaw_y));
        yaw_src[0].z   = '0;
        pitch_src[0].x = signed'(CRD_W'(pitch_x));
        pitch_src[0].y = signed'(CRD_W'(pitch_y));
        pitch_src[0].z = '0;
        flag_src[0]    = flags_in;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            yaw_src[i]   = yaw_reg[i-1];
            pitch_src[i] = pitch_reg[i-1];
            flag_src[i]  = flag_reg[i-1];
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            yaw_next[i]   = crd_step(yaw_src[i], i);
            pitch_next[i] = crd_step(pitch_src[i], i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[CORDIC_STEPS-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        yaw_reg   <= yaw_next;
        pitch_reg <= pitch_next;
        flag_reg  <= flag_src;
    end

    assign valid_out = v_reg[CORDIC_STEPS-1];
    assign yaw_z     = yaw_reg[CORDIC_STEPS-1].z;
    assign pitch_z   = pitch_reg[CORDIC_STEPS-1].z;
    assign flags_out = flag_reg[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// File: src/billboard_orientation_angles.sv
`default_nettype none

// Billboard orientation: a start beat is taken in every cycle (busy stays low) and its
// result appears with done high, one beat out per beat in. The pipeline runs through
// registers for difference, scaling and exact cosine-limit tests, a 31-stage square
// root for the pitch projection length and a 23-stage dual CORDIC, then clamping and
// rounding registers. The receiver cannot stall, so nothing is held back.
// cos_limit may only be written while no beat is in flight.
module billboard_orientation_angles (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                cos_limit_we,
    input  wire logic [bboa_pkg::LIM_W-1:0]          cos_limit_wdata,
    input  wire logic signed [bboa_pkg::COORD_WIDTH-1:0] cam_x,
    input  wire logic signed [bboa_pkg::COORD_WIDTH-1:0] cam_y,
    input  wire logic signed [bboa_pkg::COORD_WIDTH-1:0] cam_z,
    input  wire logic signed [bboa_pkg::COORD_WIDTH-1:0] obj_x,
    input  wire logic signed [bboa_pkg::COORD_WIDTH-1:0] obj_y,
    input  wire logic signed [bboa_pkg::COORD_WIDTH-1:0] obj_z,
    output logic                                     done,
    output logic                                     yaw_apply,
    output logic [bboa_pkg::YAW_W-1:0]               yaw_angle,
    output logic                                     yaw_axis_negative,
    output logic                                     pitch_apply,
    output logic [bboa_pkg::PITCH_W-1:0]             pitch_angle,
    output logic                                     pitch_axis_positive
);
    import bboa_pkg::*;

    localparam int LATENCY = 10 + ISQ_STEPS + CORDIC_STEPS + 2;

    function automatic logic [MAG_W-1:0] mag_of(logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] u;
        u = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return u[MAG_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] lead_pos(logic [MAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [NORM_W-1:0] norm(logic [MAG_W-1:0] v, logic [POS_W-1:0] p);
        logic [MAG_W+NORM_W-1:0] w;
        w = (MAG_W + NORM_W)'(v);
        if (p >= POS_W'(NORM_TOP))
        begin
            w = w >> (p - POS_W'(NORM_TOP));
        end
        else
        begin
            w = w << (POS_W'(NORM_TOP) - p);
        end
        return w[NORM_W-1:0];
    endfunction

    logic [LIM_W-1:0] cos_limit_reg;
    logic [L2_W-1:0]  l2_reg;

    // front pipeline
    logic [10:1] v_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic [MAG_W-1:0] ax2_reg, ay2_reg, az2_reg, ax3_reg, ay3_reg, az3_reg;
    logic             zero2_reg, zero3_reg, zero4_reg, zero5_reg, zero6_reg;
    logic             zero7_reg, zero8_reg, zero9_reg;
    logic [2:0]       neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [2:0]       neg7_reg, neg8_reg, neg9_reg, neg10_reg;
    logic [POS_W-1:0] posy3_reg, posp3_reg;
    logic [NORM_W-1:0] yx4_reg, yz4_reg, px4_reg, py4_reg, pz4_reg;
    logic [NORM_W-1:0] yx5_reg, yz5_reg, py5_reg, yx6_reg, yz6_reg, py6_reg;
    logic [NORM_W-1:0] yx7_reg, yz7_reg, py7_reg, yx8_reg, yz8_reg, py8_reg;
    logic [NORM_W-1:0] yx9_reg, yz9_reg, py9_reg, yx10_reg, yz10_reg, py10_reg;
    logic [SQ_W-1:0]  yxs5_reg, yzs5_reg, pxs5_reg, pys5_reg, pzs5_reg;
    logic [SQ_W-1:0]  yzs6_reg, pys6_reg, yzs7_reg, yzs8_reg;
    logic [SUM_W-1:0] ry6_reg, s6_reg, s7_reg, s8_reg, s9_reg, s10_reg;
    logic [T_W-1:0]   t7_reg;
    logic [PL_W-1:0]  ylo7_reg, plo8_reg;
    logic [PH_W-1:0]  yhi7_reg, phi8_reg;
    logic [CMP_W-1:0] ysum8_reg, psum9_reg;
    logic             yok9_reg, yok10_reg, pok10_reg;

    isq_side_t            isq_side;
    logic                 isq_valid;
    logic [ROOT_W-1:0]    isq_root;
    isq_side_t            isq_side_out;
    logic                 crd_valid;
    logic signed [ANG_W-1:0] crd_yaw_z, crd_pitch_z;
    flag_t                crd_flags;

    logic                 f1_v_reg;
    flag_t                f1_flags_reg;
    logic [UA_W-1:0]      f1_yaw_reg, f1_pitch_reg;
    logic [UA_W-1:0]      yaw_clamp, pitch_clamp;
    logic [UA_W:0]        yaw_round, pitch_round;

    logic                 done_reg, yaw_apply_reg, yaw_neg_reg, pitch_apply_reg, pitch_pos_reg;
    logic [YAW_W-1:0]     yaw_angle_reg;
    logic [PITCH_W-1:0]   pitch_angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_limit_reg <= COS_LIMIT_RESET;
            v_reg         <= '0;
            f1_v_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cos_limit_we)
            begin
                cos_limit_reg <= cos_limit_wdata;
            end
            v_reg    <= {v_reg[9:1], start};
            f1_v_reg <= crd_valid;
            done_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l2_reg <= L2_W'(cos_limit_reg) * L2_W'(cos_limit_reg);

        dx1_reg <= DIFF_W'(cam_x) - DIFF_W'(obj_x);
        dy1_reg <= DIFF_W'(cam_y) - DIFF_W'(obj_y);
        dz1_reg <= DIFF_W'(cam_z) - DIFF_W'(obj_z);

        ax2_reg   <= mag_of(dx1_reg);
        ay2_reg   <= mag_of(dy1_reg);
        az2_reg   <= mag_of(dz1_reg);
        zero2_reg <= (dx1_reg == '0) && (dz1_reg == '0);
        neg2_reg  <= {dx1_reg[DIFF_W-1], dy1_reg[DIFF_W-1], dz1_reg[DIFF_W-1]};

        ax3_reg   <= ax2_reg;
        ay3_reg   <= ay2_reg;
        az3_reg   <= az2_reg;
        posy3_reg <= lead_pos(ax2_reg | az2_reg);
        posp3_reg <= lead_pos(ax2_reg | ay2_reg | az2_reg);
        zero3_reg <= zero2_reg;
        neg3_reg  <= neg2_reg;

        yx4_reg   <= norm(ax3_reg, posy3_reg);
        yz4_reg   <= norm(az3_reg, posy3_reg);
        px4_reg   <= norm(ax3_reg, posp3_reg);
        py4_reg   <= norm(ay3_reg, posp3_reg);
        pz4_reg   <= norm(az3_reg, posp3_reg);
        zero4_reg <= zero3_reg;
        neg4_reg  <= neg3_reg;

        yxs5_reg  <= SQ_W'(yx4_reg) * SQ_W'(yx4_reg);
        yzs5_reg  <= SQ_W'(yz4_reg) * SQ_W'(yz4_reg);
        pxs5_reg  <= SQ_W'(px4_reg) * SQ_W'(px4_reg);
        pys5_reg  <= SQ_W'(py4_reg) * SQ_W'(py4_reg);
        pzs5_reg  <= SQ_W'(pz4_reg) * SQ_W'(pz4_reg);
        yx5_reg   <= yx4_reg;
        yz5_reg   <= yz4_reg;
        py5_reg   <= py4_reg;
        zero5_reg <= zero4_reg;
        neg5_reg  <= neg4_reg;

        ry6_reg   <= SUM_W'(yxs5_reg) + SUM_W'(yzs5_reg);
        s6_reg    <= SUM_W'(pxs5_reg) + SUM_W'(pzs5_reg);
        pys6_reg  <= pys5_reg;
        yzs6_reg  <= yzs5_reg;
        yx6_reg   <= yx5_reg;
        yz6_reg   <= yz5_reg;
        py6_reg   <= py5_reg;
        zero6_reg <= zero5_reg;
        neg6_reg  <= neg5_reg;

        // cos_limit^2 * r, split at bit 32
        t7_reg    <= T_W'(s6_reg) + T_W'(pys6_reg);
        ylo7_reg  <= PL_W'(l2_reg) * PL_W'(ry6_reg[L2_W-1:0]);
        yhi7_reg  <= PH_W'(l2_reg) * PH_W'(ry6_reg[SUM_W-1:L2_W]);
        s7_reg    <= s6_reg;
        yzs7_reg  <= yzs6_reg;
        yx7_reg   <= yx6_reg;
        yz7_reg   <= yz6_reg;
        py7_reg   <= py6_reg;
        zero7_reg <= zero6_reg;
        neg7_reg  <= neg6_reg;

        plo8_reg  <= PL_W'(l2_reg) * PL_W'(t7_reg[L2_W-1:0]);
        phi8_reg  <= PH_W'(l2_reg) * PH_W'(t7_reg[T_W-1:L2_W]);
        ysum8_reg <= {yhi7_reg, L2_W'(0)} + CMP_W'(ylo7_reg);
        s8_reg    <= s7_reg;
        yzs8_reg  <= yzs7_reg;
        yx8_reg   <= yx7_reg;
        yz8_reg   <= yz7_reg;
        py8_reg   <= py7_reg;
        zero8_reg <= zero7_reg;
        neg8_reg  <= neg7_reg;

        yok9_reg  <= CMP_W'({yzs8_reg, L2_W'(0)}) < ysum8_reg;
        psum9_reg <= {phi8_reg, L2_W'(0)} + CMP_W'(plo8_reg);
        s9_reg    <= s8_reg;
        yx9_reg   <= yx8_reg;
        yz9_reg   <= yz8_reg;
        py9_reg   <= py8_reg;
        zero9_reg <= zero8_reg;
        neg9_reg  <= neg8_reg;

        yok10_reg <= yok9_reg && !zero9_reg;
        pok10_reg <= (CMP_W'({s9_reg, L2_W'(0)}) < psum9_reg) && !zero9_reg;
        s10_reg   <= s9_reg;
        yx10_reg  <= yx9_reg;
        yz10_reg  <= yz9_reg;
        py10_reg  <= py9_reg;
        neg10_reg <= neg9_reg;
    end

    always_comb
    begin
        isq_side.f.yaw_ok   = yok10_reg;
        isq_side.f.pitch_ok = pok10_reg;
        isq_side.f.dx_neg   = neg10_reg[2];
        isq_side.f.dy_neg   = neg10_reg[1];
        isq_side.f.dz_neg   = neg10_reg[0];
        isq_side.yx         = yx10_reg;
        isq_side.yz         = yz10_reg;
        isq_side.py         = py10_reg;
    end

    bboa_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v_reg[10]),
        .s_in      (s10_reg),
        .side_in   (isq_side),
        .valid_out (isq_valid),
        .root_out  (isq_root),
        .side_out  (isq_side_out)
    );

    bboa_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (isq_valid),
        .yaw_x     (isq_side_out.yz),
        .yaw_y     (isq_side_out.yx),
        .pitch_x   (isq_root),
        .pitch_y   (isq_side_out.py),
        .flags_in  (isq_side_out.f),
        .valid_out (crd_valid),
        .yaw_z     (crd_yaw_z),
        .pitch_z   (crd_pitch_z),
        .flags_out (crd_flags)
    );

    always_comb
    begin
        if (crd_yaw_z < 0)
            yaw_clamp = '0;
        else if (crd_yaw_z > signed'(ANG_W'(DEG90_Q16)))
            yaw_clamp = DEG90_Q16;
        else
            yaw_clamp = crd_yaw_z[UA_W-1:0];

        if (crd_pitch_z < 0)
            pitch_clamp = '0;
        else if (crd_pitch_z > signed'(ANG_W'(DEG90_Q16)))
            pitch_clamp = DEG90_Q16;
        else
            pitch_clamp = crd_pitch_z[UA_W-1:0];

        yaw_round   = (UA_W + 1)'(f1_yaw_reg) + (UA_W + 1)'(HALF_UNIT);
        pitch_round = (UA_W + 1)'(f1_pitch_reg) + (UA_W + 1)'(HALF_UNIT);
    end

    always_ff @(posedge clk)
    begin
        f1_flags_reg <= crd_flags;
        f1_yaw_reg   <= crd_flags.dz_neg ? DEG180_Q16 - yaw_clamp : yaw_clamp;
        f1_pitch_reg <= pitch_clamp;

        yaw_apply_reg   <= f1_flags_reg.yaw_ok;
        yaw_neg_reg     <= f1_flags_reg.yaw_ok && f1_flags_reg.dx_neg;
        yaw_angle_reg   <= f1_flags_reg.yaw_ok ? yaw_round[YAW_W+8:9] : '0;
        pitch_apply_reg <= f1_flags_reg.pitch_ok;
        pitch_pos_reg   <= f1_flags_reg.pitch_ok && f1_flags_reg.dy_neg;
        pitch_angle_reg <= f1_flags_reg.pitch_ok ? pitch_round[PITCH_W+8:9] : '0;
    end

    assign busy                = 1'b0;
    assign done                = done_reg;
    assign yaw_apply           = yaw_apply_reg;
    assign yaw_angle           = yaw_angle_reg;
    assign yaw_axis_negative   = yaw_neg_reg;
    assign pitch_apply         = pitch_apply_reg;
    assign pitch_angle         = pitch_angle_reg;
    assign pitch_axis_positive = pitch_pos_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("beat lost in pipeline");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && yaw_apply |-> yaw_angle <= YAW_W'(23040))
        else $error("yaw angle out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && pitch_apply |-> pitch_angle <= PITCH_W'(11520))
        else $error("pitch angle out of range");

    a_yaw_off: assert property (@(posedge clk) disable iff (!rst_n)
        done && !yaw_apply |-> yaw_angle == '0 && !yaw_axis_negative)
        else $error("yaw fields set without rotation");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bboa_pkg::*;

    localparam int  PIPE_DRAIN  = 70;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 2000;

    typedef struct packed {
        logic               yaw_apply;
        logic [YAW_W-1:0]   yaw_angle;
        logic               yaw_axis_negative;
        logic               pitch_apply;
        logic [PITCH_W-1:0] pitch_angle;
        logic               pitch_axis_positive;
    } orient_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] cx, cy, cz, ox, oy, oz;
    } coords_t;

    typedef struct packed {
        coords_t c;
        logic    typed;
        orient_t want;
    } row_t;

    localparam orient_t NO_ROT = '0;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cos_limit_we;
    logic [LIM_W-1:0] cos_limit_wdata;
    logic signed [COORD_WIDTH-1:0] cam_x, cam_y, cam_z, obj_x, obj_y, obj_z;
    logic done;
    logic yaw_apply;
    logic [YAW_W-1:0] yaw_angle;
    logic yaw_axis_negative;
    logic pitch_apply;
    logic [PITCH_W-1:0] pitch_angle;
    logic pitch_axis_positive;

    billboard_orientation_angles dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cos_limit_we(cos_limit_we), .cos_limit_wdata(cos_limit_wdata),
        .cam_x(cam_x), .cam_y(cam_y), .cam_z(cam_z),
        .obj_x(obj_x), .obj_y(obj_y), .obj_z(obj_z),
        .done(done), .yaw_apply(yaw_apply), .yaw_angle(yaw_angle),
        .yaw_axis_negative(yaw_axis_negative), .pitch_apply(pitch_apply),
        .pitch_angle(pitch_angle), .pitch_axis_positive(pitch_axis_positive)
    );

    logic [LIM_W-1:0] lim_model;
    orient_t          pending_orient[$];
    int               errors;
    int               cycles;

    localparam row_t DIRECTED [20] = '{
        '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, NO_ROT},
        '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1'b1, NO_ROT},
        '{'{32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, NO_ROT},
        '{'{32'h0, 32'h7fffffff, 32'h0, 32'h0, 32'h80000000, 32'h0}, 1'b1, NO_ROT},
        '{'{32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0}, 1'b1, NO_ROT},
        '{'{32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0, 32'h80000000}, 1'b1, NO_ROT},
        '{'{32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000}, 1'b0, NO_ROT},
        '{'{32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000}, 1'b0, NO_ROT},
        '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, NO_ROT},
        '{'{32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1'b0, NO_ROT},
        '{'{32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h1, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h1, 32'h7fffffff, 32'h1, 32'h0, 32'h80000000, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h7fffffff, 32'h0, 32'h1, 32'h80000000, 32'h0, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h1, 32'h0, 32'h7fffffff, 32'h0, 32'h0, 32'h80000000}, 1'b0, NO_ROT},
        '{'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ROT},
        '{'{32'h00001000, 32'hffff0000, 32'h80000000,
            32'h00002000, 32'h00010000, 32'h7fffffff}, 1'b0, NO_ROT}
    };

    function automatic void scale_dir(input logic [63:0] m, output int n, output int dir);
        n = 0;
        dir = 0;
        while (m >= 64'd1 << 30)
        begin
            m = m >> 1;
            n++;
            dir = 1;
        end
        while (m < 64'd1 << 29)
        begin
            m = m << 1;
            n++;
            dir = -1;
        end
    endfunction

    function automatic logic [63:0] rescale(input logic [63:0] v, input int n, input int dir);
        if (dir > 0)
            return v >> n;
        if (dir < 0)
            return v << n;
        return v;
    endfunction

    // exact: q * 2^32 < lim^2 * r
    function automatic bit under_limit(input logic [63:0] q, input logic [63:0] r);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = {64'd0, q} << 32;
        rhs = 128'(lim_model) * 128'(lim_model) * 128'(r);
        return lhs < rhs;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint atan_deg_q16(input longint x, input longint y);
        longint z;
        longint nx;
        longint ny;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += longint'(ATAN_Q16[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= longint'(ATAN_Q16[i]);
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            z = 0;
        if (z > longint'(DEG90_Q16))
            z = longint'(DEG90_Q16);
        return z;
    endfunction

    function automatic orient_t predict_orient(input coords_t c);
        orient_t o;
        longint dx, dy, dz, a;
        logic [63:0] ax, ay, az, m, yx, yz, px, py, pz, s, t, u;
        int n, dir;
        o = '0;
        dx = longint'($signed(c.cx)) - longint'($signed(c.ox));
        dy = longint'($signed(c.cy)) - longint'($signed(c.oy));
        dz = longint'($signed(c.cz)) - longint'($signed(c.oz));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        az = dz < 0 ? -dz : dz;
        if (ax == 0 && az == 0)
            return o;
        m = ax > az ? ax : az;
        scale_dir(m, n, dir);
        yx = rescale(ax, n, dir);
        yz = rescale(az, n, dir);
        if (under_limit(yz * yz, yx * yx + yz * yz))
        begin
            a = atan_deg_q16(longint'(yz), longint'(yx));
            if (dz < 0)
                a = longint'(DEG180_Q16) - a;
            u = (64'(a) + 64'(HALF_UNIT)) >> 9;
            o.yaw_apply = 1'b1;
            o.yaw_angle = u[YAW_W-1:0];
            o.yaw_axis_negative = dx < 0;
        end
        if (ay > m)
            m = ay;
        scale_dir(m, n, dir);
        px = rescale(ax, n, dir);
        py = rescale(ay, n, dir);
        pz = rescale(az, n, dir);
        s = px * px + pz * pz;
        t = s + py * py;
        if (under_limit(s, t))
        begin
            a = atan_deg_q16(longint'(floor_sqrt(s)), longint'(py));
            u = (64'(a) + 64'(HALF_UNIT)) >> 9;
            o.pitch_apply = 1'b1;
            o.pitch_angle = u[PITCH_W-1:0];
            o.pitch_axis_positive = dy < 0;
        end
        return o;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("billboard_orientation_angles verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        orient_t got;
        orient_t want;
        if (rst_n && done)
        begin
            got = '{yaw_apply, yaw_angle, yaw_axis_negative,
                    pitch_apply, pitch_angle, pitch_axis_positive};
            if (pending_orient.size() == 0)
            begin
                $display("%0t: result beat with nothing pending, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_orient.pop_front();
                if (got.yaw_apply !== want.yaw_apply)
                begin
                    $display("%0t: yaw_apply exp %0d act %0d", $time,
                             want.yaw_apply, got.yaw_apply);
                    errors++;
                end
                if (got.yaw_angle !== want.yaw_angle)
                begin
                    $display("%0t: yaw_angle exp %0d act %0d", $time,
                             want.yaw_angle, got.yaw_angle);
                    errors++;
                end
                if (got.yaw_axis_negative !== want.yaw_axis_negative)
                begin
                    $display("%0t: yaw_axis_negative exp %0d act %0d", $time,
                             want.yaw_axis_negative, got.yaw_axis_negative);
                    errors++;
                end
                if (got.pitch_apply !== want.pitch_apply)
                begin
                    $display("%0t: pitch_apply exp %0d act %0d", $time,
                             want.pitch_apply, got.pitch_apply);
                    errors++;
                end
                if (got.pitch_angle !== want.pitch_angle)
                begin
                    $display("%0t: pitch_angle exp %0d act %0d", $time,
                             want.pitch_angle, got.pitch_angle);
                    errors++;
                end
                if (got.pitch_axis_positive !== want.pitch_axis_positive)
                begin
                    $display("%0t: pitch_axis_positive exp %0d act %0d", $time,
                             want.pitch_axis_positive, got.pitch_axis_positive);
                    errors++;
                end
            end
        end
    end

    // called at a rising edge; returns at the edge that took the beat
    task automatic send_beat(input coords_t c, input bit typed, input orient_t want);
        start <= 1'b1;
        cam_x <= c.cx;
        cam_y <= c.cy;
        cam_z <= c.cz;
        obj_x <= c.ox;
        obj_y <= c.oy;
        obj_z <= c.oz;
        @(posedge clk iff !busy);
        if (typed)
            pending_orient.push_back(want);
        else
            pending_orient.push_back(predict_orient(c));
    endtask

    task automatic idle_gap(input bit calm);
        if (!calm && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_orient.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIM_W-1:0] v);
        drain();
        cos_limit_we <= 1'b1;
        cos_limit_wdata <= v;
        @(posedge clk);
        cos_limit_we <= 1'b0;
        lim_model = v;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(input int style);
        case (style)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 32'h0;
        endcase
    endfunction

    function automatic coords_t rand_item();
        coords_t c;
        int kind;
        logic [31:0] base;
        kind = $urandom_range(9);
        c.cx = rand_coord(0);
        c.cy = rand_coord(0);
        c.cz = rand_coord(0);
        c.ox = rand_coord(0);
        c.oy = rand_coord(0);
        c.oz = rand_coord(0);
        case (kind)
            0, 1, 2:
            begin
                base = $urandom();
                c.ox = base;
                c.cx = base + rand_coord(1);
                base = $urandom();
                c.oy = base;
                c.cy = base + rand_coord(1);
                base = $urandom();
                c.oz = base;
                c.cz = base + rand_coord(1);
            end
            3: c.cx = c.ox;
            4: c.cz = c.oz;
            5:
            begin
                c.cx = c.ox;
                c.cz = c.oz + ($urandom_range(1) ? 32'd1 : 32'hffffffff);
            end
            6: c.cy = c.oy;
            7:
            begin
                c.cx = c.ox;
                c.cz = c.oz;
            end
            default: ;
        endcase
        return c;
    endfunction

    initial
    begin
        logic [LIM_W-1:0] limits [6];
        rst_n = 1'b0;
        start = 1'b0;
        cos_limit_we = 1'b0;
        cos_limit_wdata = '0;
        cam_x = '0;
        cam_y = '0;
        cam_z = '0;
        obj_x = '0;
        obj_y = '0;
        obj_z = '0;
        lim_model = COS_LIMIT_RESET;
        errors = 0;
        cycles = 0;
        limits = '{16'd0, 16'd65535, 16'd32768, 16'd60000, 16'd65000, 16'd0};
        limits[5] = 16'($urandom());
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_beat(DIRECTED[i].c, DIRECTED[i].typed, DIRECTED[i].want);
            idle_gap(1'b0);
        end

        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
                set_limit(limits[p-1]);
            for (int k = 0; k < N_RANDOM / 7; k++)
            begin
                send_beat(rand_item(), 1'b0, NO_ROT);
                if (p == 0 && k == 100)
                    drain();
                idle_gap(p == 3 && k > 50 && k < 250);
            end
        end

        drain();
        if (errors == 0)
            $display("billboard_orientation_angles verification clean");
        else
            $display("billboard_orientation_angles verification failed");
        $finish;
    end

endmodule
